// File: hdl/png_unf_pkg.sv
// Shared types and constants for the PNG RGB8 scanline unfilter.
// Holds the filter type codes and the widths of the line buffer and counters.
// No dependencies.
`default_nettype none

package png_unf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int BPP        = 3;
  localparam int LINE_DEPTH = MAX_WIDTH * BPP;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int CFG_W      = COL_W + 1;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int CH_W       = 2;

  localparam logic [CH_W-1:0] CH_LAST = CH_W'(BPP - 1);

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

endpackage

`default_nettype wire

// File: hdl/png_unf_if.sv
// Valid/ready channel interfaces for the input bytes and the rebuilt bytes.
// Depends on png_unf_pkg for the channel and column widths.
`default_nettype none

interface png_unf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface png_unf_out_if import png_unf_pkg::*;;
  logic             valid;
  logic             ready;
  logic [7:0]       pixel_byte;
  logic [CH_W-1:0]  channel;
  logic [COL_W-1:0] column;
  logic             row_end;
  logic             error;

  modport source (output valid, output pixel_byte, output channel, output column,
                  output row_end, output error, input ready);
  modport sink   (input valid, input pixel_byte, input channel, input column,
                  input row_end, input error, output ready);
endinterface

`default_nettype wire

// File: hdl/png_unf_predict.sv
// Filter predictor and reconstruction adder for one colour byte.
// Depends on png_unf_pkg for the filter type codes.
`default_nettype none

module png_unf_predict import png_unf_pkg::*; (
  input  filt_t      filt,
  input  logic [7:0] raw,
  input  logic [7:0] left_a,
  input  logic [7:0] up_b,
  input  logic [7:0] ul_c,
  output logic [7:0] recon
);

  function automatic logic [7:0] nearest_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
    logic signed [10:0] sa;
    logic signed [10:0] sb;
    logic signed [10:0] sc;
    logic signed [10:0] p;
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic signed [10:0] pa;
    logic signed [10:0] pb;
    logic signed [10:0] pc;
    sa = signed'({3'b000, a});
    sb = signed'({3'b000, b});
    sc = signed'({3'b000, c});
    p  = sa + sb - sc;
    da = p - sa;
    db = p - sb;
    dc = p - sc;
    pa = (da < 0) ? -da : da;
    pb = (db < 0) ? -db : db;
    pc = (dc < 0) ? -dc : dc;
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end
    return c;
  endfunction

  logic [8:0] avg_sum;
  logic [7:0] pred;

  assign avg_sum = {1'b0, left_a} + {1'b0, up_b};

  always_comb begin
    case (filt)
      FILT_SUB:   pred = left_a;
      FILT_UP:    pred = up_b;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = nearest_pick(left_a, up_b, ul_c);
      default:    pred = 8'd0;
    endcase
  end

  assign recon = raw + pred;

endmodule

`default_nettype wire

// File: hdl/png_rgb8_scanline_unfilter_unit.sv
// Top level of the PNG RGB8 scanline unfilter.
// Depends on png_unf_pkg, png_unf_if and png_unf_predict.
//
// The unit takes one byte of decompressed image data per clock and returns
// at most one rebuilt colour byte per input byte, sustaining one transfer per
// cycle on both sides while the output is not stalled. An accepted byte is
// held in an input register and its result is written to the output register
// when the byte leaves the input register. The previous row lives in a
// 3072 x 8 line buffer with one write and one registered read per cycle; the
// read for the next byte position is issued while the current byte is being
// processed, so the buffer never limits the rate. A valid filter-type byte
// gives no result; an invalid one gives an error result. The buffer needs no
// clearing after reset, as the first row of each frame never reads it. The
// width register should only be written while the unit is idle.
`default_nettype none

module png_rgb8_scanline_unfilter_unit import png_unf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  png_unf_in_if.sink       in_ch,
  png_unf_out_if.source    out_ch
);

  logic [CFG_W-1:0] row_width_r;
  logic [CFG_W-1:0] width_eff;

  logic             s1_valid_r;
  logic [7:0]       s1_data_r;
  logic             s1_fs_r;

  logic [7:0]       left_r [BPP];
  logic [7:0]       ul_r [BPP];
  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] col_nxt;
  logic [CH_W-1:0]  ch_r;
  logic [CH_W-1:0]  ch_nxt;
  logic             first_row_r;
  logic             first_row_nxt;
  logic             expect_r;
  logic             expect_nxt;
  filt_t            filt_r;
  filt_t            filt_nxt;
  logic             err_r;
  logic             err_nxt;

  logic             eff_err;
  logic             eff_expect;
  logic             eff_first;
  logic             bad_filt;
  logic             is_data;
  logic             produces;
  logic             consume;
  logic             out_free;

  logic [7:0]       a_byte;
  logic [7:0]       b_byte;
  logic [7:0]       c_byte;
  logic [7:0]       recon;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] rd_addr;
  logic             last_col;
  logic             row_end;

  logic [7:0]       line_mem [LINE_DEPTH];
  logic [7:0]       rd_data_r;

  logic             out_valid_r;
  logic [7:0]       out_pixel_r;
  logic [CH_W-1:0]  out_ch_r;
  logic [COL_W-1:0] out_col_r;
  logic             out_end_r;
  logic             out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= CFG_W'(1);
    end else if (cfg_we) begin
      row_width_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (row_width_r == '0) begin
      width_eff = CFG_W'(1);
    end else if (row_width_r > CFG_W'(MAX_WIDTH)) begin
      width_eff = CFG_W'(MAX_WIDTH);
    end else begin
      width_eff = row_width_r;
    end
  end

  assign eff_err    = err_r && !s1_fs_r;
  assign eff_expect = expect_r || s1_fs_r;
  assign eff_first  = first_row_r || s1_fs_r;
  assign bad_filt   = eff_expect && (s1_data_r > {5'b00000, FILT_PAETH});
  assign is_data    = !eff_err && !eff_expect;
  assign produces   = !eff_err && (bad_filt || !eff_expect);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign consume    = s1_valid_r && (out_free || !produces);
  assign in_ch.ready = !s1_valid_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (consume) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_data_r <= in_ch.data_byte;
      s1_fs_r   <= in_ch.frame_start;
    end
  end

  assign idx    = ADDR_W'({col_r, 1'b0}) + ADDR_W'(col_r) + ADDR_W'(ch_r);
  assign a_byte = (col_r != '0) ? left_r[ch_r] : 8'd0;
  assign b_byte = first_row_r ? 8'd0 : rd_data_r;
  assign c_byte = (col_r != '0 && !first_row_r) ? ul_r[ch_r] : 8'd0;

  png_unf_predict u_predict (
    .filt   (filt_r),
    .raw    (s1_data_r),
    .left_a (a_byte),
    .up_b   (b_byte),
    .ul_c   (c_byte),
    .recon  (recon)
  );

  assign last_col = ({1'b0, col_r} + CFG_W'(1)) >= width_eff;
  assign row_end  = (ch_r == CH_LAST) && last_col;

  always_comb begin
    col_nxt       = col_r;
    ch_nxt        = ch_r;
    first_row_nxt = first_row_r;
    expect_nxt    = expect_r;
    filt_nxt      = filt_r;
    err_nxt       = err_r;
    if (consume && !eff_err) begin
      if (eff_expect) begin
        col_nxt       = '0;
        ch_nxt        = '0;
        first_row_nxt = eff_first;
        if (bad_filt) begin
          err_nxt    = 1'b1;
          expect_nxt = 1'b1;
          filt_nxt   = FILT_NONE;
        end else begin
          err_nxt    = 1'b0;
          expect_nxt = 1'b0;
          filt_nxt   = filt_t'(s1_data_r[2:0]);
        end
      end else if (ch_r == CH_LAST) begin
        ch_nxt = '0;
        if (last_col) begin
          col_nxt       = '0;
          first_row_nxt = 1'b0;
          expect_nxt    = 1'b1;
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end else begin
        ch_nxt = ch_r + CH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      ch_r        <= '0;
      first_row_r <= 1'b1;
      expect_r    <= 1'b1;
      filt_r      <= FILT_NONE;
      err_r       <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      ch_r        <= ch_nxt;
      first_row_r <= first_row_nxt;
      expect_r    <= expect_nxt;
      filt_r      <= filt_nxt;
      err_r       <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && is_data) begin
      left_r[ch_r] <= recon;
      ul_r[ch_r]   <= b_byte;
    end
  end

  assign rd_addr = ADDR_W'({col_nxt, 1'b0}) + ADDR_W'(col_nxt) + ADDR_W'(ch_nxt);

  always_ff @(posedge clk) begin
    if (consume && is_data) begin
      line_mem[idx] <= recon;
    end
    rd_data_r <= line_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= consume && produces;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && produces) begin
      out_pixel_r <= bad_filt ? 8'd0 : recon;
      out_ch_r    <= bad_filt ? '0 : ch_r;
      out_col_r   <= bad_filt ? '0 : col_r;
      out_end_r   <= bad_filt ? 1'b0 : row_end;
      out_err_r   <= bad_filt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_byte = out_pixel_r;
  assign out_ch.channel    = out_ch_r;
  assign out_ch.column     = out_col_r;
  assign out_ch.row_end    = out_end_r;
  assign out_ch.error      = out_err_r;

`ifndef SYNTHESIS
  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    ch_r <= CH_LAST)
    else $error("Channel position left the pixel.");

  a_err_sets_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    consume && !eff_err && bad_filt |=> err_r)
    else $error("A bad filter byte did not set the sticky error.");

  a_err_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_pixel_r == 8'd0 && out_col_r == '0 && !out_end_r)
    else $error("Error result carries pixel data.");

  a_row_end_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_end_r |-> out_ch_r == CH_LAST)
    else $error("Row ended on a byte that is not the last channel.");

  a_sticky_drops: assert property (@(posedge clk) disable iff (!rst_n)
    consume && eff_err |-> !produces)
    else $error("A byte produced a result while the error was set.");
`endif

endmodule

`default_nettype wire
